/* src/ookpd_pkg.sv */
// shared types and constants for the on-off-keyed pulse distance receiver
`timescale 1ns / 1ps
`default_nettype none

package ookpd_pkg;

    localparam int CODE_WIDTH     = 64;
    localparam int TIME_WIDTH     = 32;
    localparam int CFG_DATA_WIDTH = 16;
    localparam int CFG_IDX_WIDTH  = 3;
    localparam int FRAME_BITS_W   = 7;
    localparam int COUNT_WIDTH    = 8;
    localparam int TIME_PORT_W    = 32;
    localparam int CODE_PORT_W    = 64;

    localparam logic [CFG_DATA_WIDTH-1:0] PULSE_MIN_RST = 16'd460;
    localparam logic [CFG_DATA_WIDTH-1:0] PULSE_MAX_RST = 16'd800;
    localparam logic [CFG_DATA_WIDTH-1:0] GAP_MIN_RST   = 16'd2500;
    localparam logic [CFG_DATA_WIDTH-1:0] GAP_ONE_RST   = 16'd4500;
    localparam logic [CFG_DATA_WIDTH-1:0] GAP_MAX_RST   = 16'd5000;
    localparam logic [CFG_DATA_WIDTH-1:0] SYNC_MIN_RST  = 16'd9500;
    localparam logic [FRAME_BITS_W-1:0]   FRAME_BITS_RST = 7'd37;

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        REG_PULSE_MIN  = 3'd0,
        REG_PULSE_MAX  = 3'd1,
        REG_GAP_MIN    = 3'd2,
        REG_GAP_ONE    = 3'd3,
        REG_GAP_MAX    = 3'd4,
        REG_SYNC_MIN   = 3'd5,
        REG_FRAME_BITS = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic [CFG_DATA_WIDTH-1:0] pulse_min;
        logic [CFG_DATA_WIDTH-1:0] pulse_max;
        logic [CFG_DATA_WIDTH-1:0] gap_min;
        logic [CFG_DATA_WIDTH-1:0] gap_one;
        logic [CFG_DATA_WIDTH-1:0] gap_max;
        logic [CFG_DATA_WIDTH-1:0] sync_min;
        logic [FRAME_BITS_W-1:0]   frame_bits;
    } cfg_t;

    typedef struct packed {
        logic                   rising_edge;
        logic [TIME_PORT_W-1:0] edge_time;
    } edge_t;

    typedef struct packed {
        logic                   frame_ready;
        logic [CODE_PORT_W-1:0] frame_code;
        logic                   symbol_ok;
    } res_t;

endpackage

`default_nettype wire

/* src/ook_pulse_distance_receiver.sv */
// top level: on-off-keyed pulse distance receiver with input and result registers
// each item is decoded out of the input register into the result register
// throughput: one item per cycle, set by the single decode stage between the registers
// a waiting result stalls the input once the input register also holds an item
// reset (aresetn low, synchronous) restores default thresholds, clears decode state
// and empties both registers
`timescale 1ns / 1ps
`default_nettype none

module ook_pulse_distance_receiver #(
    parameter int CODE_WIDTH = ookpd_pkg::CODE_WIDTH,
    parameter int TIME_WIDTH = ookpd_pkg::TIME_WIDTH
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 s_valid,
    output      logic                                 s_ready,
    input  wire logic                                 s_rising_edge,
    input  wire logic [ookpd_pkg::TIME_PORT_W-1:0]    s_edge_time,
    output      logic                                 m_valid,
    input  wire logic                                 m_ready,
    output      logic                                 m_frame_ready,
    output      logic [ookpd_pkg::CODE_PORT_W-1:0]    m_frame_code,
    output      logic                                 m_symbol_ok,
    input  wire logic                                 cfg_wr_en,
    input  wire logic [ookpd_pkg::CFG_IDX_WIDTH-1:0]  cfg_index,
    input  wire logic [ookpd_pkg::CFG_DATA_WIDTH-1:0] cfg_wdata
);

    ookpd_pkg::cfg_t  cfg;
    ookpd_pkg::edge_t in_reg;
    ookpd_pkg::res_t  res;
    ookpd_pkg::res_t  out_reg;
    logic             in_vld_reg, in_vld_next;
    logic             out_vld_reg, out_vld_next;
    logic             advance;
    logic             fire;
    logic             s_take;

    ookpd_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    ookpd_core #(
        .CODE_WIDTH (CODE_WIDTH),
        .TIME_WIDTH (TIME_WIDTH)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .edge_in (in_reg),
        .cfg     (cfg),
        .res     (res)
    );

    assign advance = !out_vld_reg || m_ready;
    assign fire    = in_vld_reg && advance;
    assign s_ready = !in_vld_reg || advance;
    assign s_take  = s_valid && s_ready;

    always_comb begin
        in_vld_next = in_vld_reg;
        if (s_take) begin
            in_vld_next = 1'b1;
        end else if (fire) begin
            in_vld_next = 1'b0;
        end
        out_vld_next = out_vld_reg;
        if (fire) begin
            out_vld_next = 1'b1;
        end else if (m_ready) begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_reg.rising_edge <= s_rising_edge;
            in_reg.edge_time   <= s_edge_time;
        end
        if (fire) begin
            out_reg <= res;
        end
    end

    assign m_valid       = out_vld_reg;
    assign m_frame_ready = out_reg.frame_ready;
    assign m_frame_code  = out_reg.frame_code;
    assign m_symbol_ok   = out_reg.symbol_ok;

    a_frame_is_activity: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_frame_ready) |-> m_symbol_ok)
        else $error("frame result without activity flag");

    a_code_zero_without_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_frame_ready) |-> (m_frame_code == '0))
        else $error("nonzero code without a frame");

    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_vld_reg && out_vld_reg && !m_ready))
        else $error("input stalled while a stage was free");

    a_result_follows_fire: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> m_valid)
        else $error("processed item produced no result");

endmodule

`default_nettype wire

/* src/ookpd_cfg.sv */
// configuration registers for thresholds and frame length
`timescale 1ns / 1ps
`default_nettype none

module ookpd_cfg (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 cfg_wr_en,
    input  wire logic [ookpd_pkg::CFG_IDX_WIDTH-1:0]  cfg_index,
    input  wire logic [ookpd_pkg::CFG_DATA_WIDTH-1:0] cfg_wdata,
    output ookpd_pkg::cfg_t                           cfg
);

    ookpd_pkg::cfg_t cfg_reg;
    ookpd_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (ookpd_pkg::reg_idx_t'(cfg_index))
                ookpd_pkg::REG_PULSE_MIN:  cfg_next.pulse_min = cfg_wdata;
                ookpd_pkg::REG_PULSE_MAX:  cfg_next.pulse_max = cfg_wdata;
                ookpd_pkg::REG_GAP_MIN:    cfg_next.gap_min   = cfg_wdata;
                ookpd_pkg::REG_GAP_ONE:    cfg_next.gap_one   = cfg_wdata;
                ookpd_pkg::REG_GAP_MAX:    cfg_next.gap_max   = cfg_wdata;
                ookpd_pkg::REG_SYNC_MIN:   cfg_next.sync_min  = cfg_wdata;
                ookpd_pkg::REG_FRAME_BITS: begin
                    cfg_next.frame_bits = cfg_wdata[ookpd_pkg::FRAME_BITS_W-1:0];
                end
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pulse_min  <= ookpd_pkg::PULSE_MIN_RST;
            cfg_reg.pulse_max  <= ookpd_pkg::PULSE_MAX_RST;
            cfg_reg.gap_min    <= ookpd_pkg::GAP_MIN_RST;
            cfg_reg.gap_one    <= ookpd_pkg::GAP_ONE_RST;
            cfg_reg.gap_max    <= ookpd_pkg::GAP_MAX_RST;
            cfg_reg.sync_min   <= ookpd_pkg::SYNC_MIN_RST;
            cfg_reg.frame_bits <= ookpd_pkg::FRAME_BITS_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

/* src/ookpd_core.sv */
// decode state and per-edge pulse, gap and frame logic
`timescale 1ns / 1ps
`default_nettype none

module ookpd_core #(
    parameter int CODE_WIDTH = ookpd_pkg::CODE_WIDTH,
    parameter int TIME_WIDTH = ookpd_pkg::TIME_WIDTH
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            fire,
    input  wire ookpd_pkg::edge_t edge_in,
    input  wire ookpd_pkg::cfg_t  cfg,
    output ookpd_pkg::res_t       res
);

    localparam int CW = ookpd_pkg::COUNT_WIDTH;

    logic [TIME_WIDTH-1:0] rise_time_reg, rise_time_next;
    logic [TIME_WIDTH-1:0] prev_start_reg, prev_start_next;
    logic [CODE_WIDTH-1:0] shift_code_reg, shift_code_next;
    logic [CW-1:0]         bit_count_reg, bit_count_next;

    logic [TIME_WIDTH-1:0] now;
    logic [TIME_WIDTH-1:0] pulse;
    logic [TIME_WIDTH-1:0] gap;
    logic                  pulse_ok;
    logic                  bit_hit;
    logic                  sync_hit;
    logic                  count_match;
    logic                  frame_hit;
    logic                  bit_val;

    assign now   = edge_in.edge_time[TIME_WIDTH-1:0];
    assign pulse = now - rise_time_reg;
    assign gap   = rise_time_reg - prev_start_reg;

    assign pulse_ok = !edge_in.rising_edge
                   && (pulse > TIME_WIDTH'(cfg.pulse_min))
                   && (pulse < TIME_WIDTH'(cfg.pulse_max));
    assign bit_hit  = (gap > TIME_WIDTH'(cfg.gap_min)) && (gap < TIME_WIDTH'(cfg.gap_max));
    assign sync_hit = !bit_hit && (gap >= TIME_WIDTH'(cfg.sync_min));
    assign bit_val  = gap > TIME_WIDTH'(cfg.gap_one);
    assign count_match = bit_count_reg == CW'(cfg.frame_bits);
    assign frame_hit   = pulse_ok && sync_hit && count_match;

    always_comb begin
        rise_time_next  = rise_time_reg;
        prev_start_next = prev_start_reg;
        shift_code_next = shift_code_reg;
        bit_count_next  = bit_count_reg;
        if (edge_in.rising_edge) begin
            rise_time_next = now;
        end else if (pulse_ok) begin
            prev_start_next = rise_time_reg;
            if (bit_hit) begin
                shift_code_next = {shift_code_reg[CODE_WIDTH-2:0], bit_val};
                bit_count_next  = bit_count_reg + CW'(1);
            end else if (sync_hit) begin
                shift_code_next = '0;
                bit_count_next  = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rise_time_reg  <= '0;
            prev_start_reg <= '0;
            shift_code_reg <= '0;
            bit_count_reg  <= '0;
        end else if (fire) begin
            rise_time_reg  <= rise_time_next;
            prev_start_reg <= prev_start_next;
            shift_code_reg <= shift_code_next;
            bit_count_reg  <= bit_count_next;
        end
    end

    always_comb begin
        res.frame_ready = frame_hit;
        res.symbol_ok   = (pulse_ok && bit_hit) || frame_hit;
        res.frame_code  = frame_hit ? ookpd_pkg::CODE_PORT_W'(shift_code_reg) : '0;
    end

endmodule

`default_nettype wire

/* sim/tb.sv */
// testbench for the pulse distance receiver: drives edge streams and checks every decode result
`timescale 1ns / 1ps

module tb;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 8;
    localparam int IDLE_PCT     = 17;
    localparam int TW           = ookpd_pkg::TIME_WIDTH;
    localparam int NW           = ookpd_pkg::COUNT_WIDTH;

    typedef enum int {
        NOISE_RANDOM_EDGE,
        NOISE_BAD_PULSE,
        NOISE_STRAY_GAP,
        NOISE_DOUBLE_RISE,
        NOISE_LONE_FALL
    } noise_t;

    logic                                 aclk          = 1'b0;
    logic                                 aresetn       = 1'b0;
    logic                                 s_valid       = 1'b0;
    logic                                 s_ready;
    logic                                 s_rising_edge = 1'b0;
    logic [ookpd_pkg::TIME_PORT_W-1:0]    s_edge_time   = '0;
    logic                                 m_valid;
    logic                                 m_ready       = 1'b0;
    logic                                 m_frame_ready;
    logic [ookpd_pkg::CODE_PORT_W-1:0]    m_frame_code;
    logic                                 m_symbol_ok;
    logic                                 cfg_wr_en     = 1'b0;
    logic [ookpd_pkg::CFG_IDX_WIDTH-1:0]  cfg_index     = '0;
    logic [ookpd_pkg::CFG_DATA_WIDTH-1:0] cfg_wdata     = '0;

    // decode model state
    ookpd_pkg::cfg_t                  thresholds;
    logic [TW-1:0]                    rise_stamp  = '0;
    logic [TW-1:0]                    start_stamp = '0;
    logic [ookpd_pkg::CODE_WIDTH-1:0] code_shift  = '0;
    logic [NW-1:0]                    bits_seen   = '0;
    ookpd_pkg::res_t                  pending_decodes[$];

    logic [ookpd_pkg::TIME_PORT_W-1:0] last_start = '0;
    bit idle_en       = 1'b1;
    int rx_hold_req   = 0;
    int rx_hold_left  = 0;
    int cycle_cnt     = 0;
    int err_cnt       = 0;
    int edges_sent    = 0;
    int results_seen  = 0;
    int frames_seen   = 0;
    int settings_used = 1;

    ook_pulse_distance_receiver u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_rising_edge (s_rising_edge),
        .s_edge_time   (s_edge_time),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_frame_ready (m_frame_ready),
        .m_frame_code  (m_frame_code),
        .m_symbol_ok   (m_symbol_ok),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // result side: random stalls plus an optional long hold-off
    always @(posedge aclk) begin
        if (rx_hold_req != 0) begin
            rx_hold_left = rx_hold_req;
            rx_hold_req  = 0;
        end
        if (rx_hold_left != 0) begin
            rx_hold_left = rx_hold_left - 1;
            m_ready <= 1'b0;
        end else if (idle_en && $urandom_range(99, 0) < IDLE_PCT) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
        err_cnt++;
        $display("[%0t] %s mismatch: got %h, want %h", $time, field, got, want);
    endtask

    always @(posedge aclk) begin : check_result
        ookpd_pkg::res_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (pending_decodes.size() == 0) begin
                report_mismatch("unexpected result", 64'(m_frame_code), 64'd0);
            end else begin
                want = pending_decodes.pop_front();
                if (m_frame_ready !== want.frame_ready)
                    report_mismatch("frame_ready", 64'(m_frame_ready), 64'(want.frame_ready));
                if (m_frame_code !== want.frame_code)
                    report_mismatch("frame_code", 64'(m_frame_code), 64'(want.frame_code));
                if (m_symbol_ok !== want.symbol_ok)
                    report_mismatch("symbol_ok", 64'(m_symbol_ok), 64'(want.symbol_ok));
                if (want.frame_ready)
                    frames_seen++;
            end
        end
    end

    function automatic void decode_edge(bit rising, logic [ookpd_pkg::TIME_PORT_W-1:0] stamp);
        logic [TW-1:0] now_t;
        logic [TW-1:0] pulse;
        logic [TW-1:0] gap;
        ookpd_pkg::res_t want;
        now_t = stamp[TW-1:0];
        want  = '0;
        if (rising) begin
            rise_stamp = now_t;
        end else begin
            pulse = now_t - rise_stamp;
            if (pulse > TW'(thresholds.pulse_min) && pulse < TW'(thresholds.pulse_max)) begin
                gap         = rise_stamp - start_stamp;
                start_stamp = rise_stamp;
                if (gap > TW'(thresholds.gap_min) && gap < TW'(thresholds.gap_max)) begin
                    code_shift     = {code_shift[ookpd_pkg::CODE_WIDTH-2:0],
                                      gap > TW'(thresholds.gap_one)};
                    bits_seen      = bits_seen + NW'(1);
                    want.symbol_ok = 1'b1;
                end else if (gap >= TW'(thresholds.sync_min)) begin
                    if (bits_seen == NW'(thresholds.frame_bits)) begin
                        want.frame_ready = 1'b1;
                        want.symbol_ok   = 1'b1;
                        want.frame_code  = ookpd_pkg::CODE_PORT_W'(code_shift);
                    end
                    code_shift = '0;
                    bits_seen  = '0;
                end
            end
        end
        pending_decodes.insert(pending_decodes.size(), want);
    endfunction

    task automatic send_edge(bit rising, logic [ookpd_pkg::TIME_PORT_W-1:0] stamp);
        s_valid       <= 1'b1;
        s_rising_edge <= rising;
        s_edge_time   <= stamp;
        do @(posedge aclk); while (!s_ready);
        decode_edge(rising, stamp);
        edges_sent++;
        if (idle_en && $urandom_range(99, 0) < IDLE_PCT) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99, 0) < IDLE_PCT);
        end
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_decodes.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [ookpd_pkg::CFG_DATA_WIDTH-1:0] reg_word(
        ookpd_pkg::cfg_t c, ookpd_pkg::reg_idx_t idx);
        logic [ookpd_pkg::CFG_DATA_WIDTH-1:0] word;
        word = ookpd_pkg::CFG_DATA_WIDTH'($urandom);
        case (idx)
            ookpd_pkg::REG_PULSE_MIN:  word = c.pulse_min;
            ookpd_pkg::REG_PULSE_MAX:  word = c.pulse_max;
            ookpd_pkg::REG_GAP_MIN:    word = c.gap_min;
            ookpd_pkg::REG_GAP_ONE:    word = c.gap_one;
            ookpd_pkg::REG_GAP_MAX:    word = c.gap_max;
            ookpd_pkg::REG_SYNC_MIN:   word = c.sync_min;
            ookpd_pkg::REG_FRAME_BITS: word[ookpd_pkg::FRAME_BITS_W-1:0] = c.frame_bits;
            default:                   word = word;
        endcase
        return word;
    endfunction

    // writes every register, then junk to the unused index
    task automatic write_config(ookpd_pkg::cfg_t c);
        for (int i = 0; i < 2 ** ookpd_pkg::CFG_IDX_WIDTH; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= i[ookpd_pkg::CFG_IDX_WIDTH-1:0];
            cfg_wdata <= reg_word(c, ookpd_pkg::reg_idx_t'(i));
            @(posedge aclk);
        end
        cfg_wr_en  <= 1'b0;
        thresholds = c;
        settings_used++;
    endtask

    function automatic ookpd_pkg::cfg_t make_cfg(logic [15:0] pmin, logic [15:0] pmax,
                                                 logic [15:0] gmin, logic [15:0] gone,
                                                 logic [15:0] gmax, logic [15:0] smin,
                                                 logic [ookpd_pkg::FRAME_BITS_W-1:0] nbits);
        ookpd_pkg::cfg_t c;
        c.pulse_min  = pmin;
        c.pulse_max  = pmax;
        c.gap_min    = gmin;
        c.gap_one    = gone;
        c.gap_max    = gmax;
        c.sync_min   = smin;
        c.frame_bits = nbits;
        return c;
    endfunction

    function automatic ookpd_pkg::cfg_t default_cfg();
        return make_cfg(ookpd_pkg::PULSE_MIN_RST, ookpd_pkg::PULSE_MAX_RST,
                        ookpd_pkg::GAP_MIN_RST, ookpd_pkg::GAP_ONE_RST,
                        ookpd_pkg::GAP_MAX_RST, ookpd_pkg::SYNC_MIN_RST,
                        ookpd_pkg::FRAME_BITS_RST);
    endfunction

    function automatic ookpd_pkg::cfg_t rand_cfg();
        ookpd_pkg::cfg_t c;
        c.pulse_min = 16'($urandom_range(1000, 50));
        c.pulse_max = c.pulse_min + 16'($urandom_range(800, 2));
        c.gap_min   = 16'($urandom_range(6000, 200));
        c.gap_max   = c.gap_min + 16'($urandom_range(6000, 2));
        c.gap_one   = 16'($urandom_range(32'(c.gap_max), 32'(c.gap_min)));
        if ($urandom_range(3, 0) == 0)
            c.sync_min = 16'($urandom_range(32'(c.gap_max), 32'(c.gap_min)));
        else
            c.sync_min = c.gap_max + 16'($urandom_range(20000, 0));
        if ($urandom_range(3, 0) == 0)
            c.frame_bits = 7'($urandom_range(40, 1));
        else
            c.frame_bits = 7'($urandom_range(12, 1));
        return c;
    endfunction

    function automatic logic [31:0] pick_between(logic [31:0] lo, logic [31:0] hi);
        if (hi <= lo)
            return lo;
        return $urandom_range(hi, lo);
    endfunction

    function automatic logic [31:0] pick_len();
        if (32'(thresholds.pulse_max) <= 32'(thresholds.pulse_min) + 32'd1)
            return $urandom_range(2000, 0);
        return pick_between(32'(thresholds.pulse_min) + 32'd1, 32'(thresholds.pulse_max) - 32'd1);
    endfunction

    function automatic logic [31:0] pick_bit_gap(bit one);
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] sub_lo;
        logic [31:0] sub_hi;
        lo = 32'(thresholds.gap_min) + 32'd1;
        if (32'(thresholds.gap_max) <= lo)
            return lo;
        hi     = 32'(thresholds.gap_max) - 32'd1;
        sub_lo = lo;
        sub_hi = hi;
        if (one && 32'(thresholds.gap_one) + 32'd1 > sub_lo)
            sub_lo = 32'(thresholds.gap_one) + 32'd1;
        if (!one && 32'(thresholds.gap_one) < sub_hi)
            sub_hi = 32'(thresholds.gap_one);
        if (sub_lo > sub_hi)
            return pick_between(lo, hi);
        return pick_between(sub_lo, sub_hi);
    endfunction

    function automatic logic [31:0] pick_sync();
        logic [31:0] floor_gap;
        floor_gap = (thresholds.sync_min > thresholds.gap_max) ? 32'(thresholds.sync_min)
                                                               : 32'(thresholds.gap_max);
        return floor_gap + $urandom_range(4000, 0);
    endfunction

    task automatic send_pulse(logic [31:0] gap, logic [31:0] len);
        last_start = last_start + gap;
        send_edge(1'b1, last_start);
        send_edge(1'b0, last_start + len);
    endtask

    // a pulse that is meant to be rejected, so the gap reference stays put
    task automatic send_stray_pulse(logic [31:0] offset, logic [31:0] len);
        send_edge(1'b1, last_start + offset);
        send_edge(1'b0, last_start + offset + len);
    endtask

    task automatic send_frame(int nbits);
        send_pulse(pick_sync(), pick_len());
        repeat (nbits) send_pulse(pick_bit_gap(1'($urandom_range(1, 0))), pick_len());
    endtask

    task automatic send_noise();
        noise_t kind;
        kind = noise_t'($urandom_range(4, 0));
        case (kind)
            NOISE_RANDOM_EDGE: send_edge(1'($urandom_range(1, 0)), $urandom);
            NOISE_BAD_PULSE:
                send_stray_pulse($urandom_range(3000, 0), ($urandom_range(1, 0) != 0) ?
                                 32'(thresholds.pulse_min) : 32'(thresholds.pulse_max));
            NOISE_STRAY_GAP:
                if (thresholds.sync_min > thresholds.gap_max)
                    send_pulse(pick_between(32'(thresholds.gap_max),
                                            32'(thresholds.sync_min) - 32'd1),
                               pick_len());
                else
                    send_pulse(pick_between(32'd0, 32'(thresholds.gap_min)), pick_len());
            NOISE_DOUBLE_RISE: begin
                send_edge(1'b1, last_start + $urandom_range(3000, 0));
                send_pulse(pick_bit_gap(1'($urandom_range(1, 0))), pick_len());
            end
            default: send_edge(1'b0, $urandom);
        endcase
    endtask

    task automatic run_frames(int n_edges, int pct_frames);
        int stop_at;
        int nbits;
        int roll;
        stop_at    = edges_sent + n_edges;
        last_start = $urandom;
        while (edges_sent < stop_at) begin
            if ($urandom_range(99, 0) < pct_frames) begin
                roll  = $urandom_range(9, 0);
                nbits = thresholds.frame_bits;
                if (roll == 0)
                    nbits = nbits + 1;
                else if (roll == 1 && nbits > 0)
                    nbits = nbits - 1;
                send_frame(nbits);
            end else begin
                send_noise();
            end
        end
        send_pulse(pick_sync(), pick_len());
        wait_idle();
    endtask

    task automatic test_window_edges();
        last_start = 32'hFFFF_F000;
        send_edge(1'b0, '0);
        send_pulse(0, 32'(ookpd_pkg::PULSE_MIN_RST) + 1);
        send_pulse(32'(ookpd_pkg::GAP_MIN_RST) + 1, 32'(ookpd_pkg::PULSE_MAX_RST) - 1);
        send_pulse(32'(ookpd_pkg::GAP_MAX_RST) - 1, 600);
        send_stray_pulse(1000, 32'(ookpd_pkg::PULSE_MIN_RST));
        send_stray_pulse(1500, 32'(ookpd_pkg::PULSE_MAX_RST));
        send_pulse(32'(ookpd_pkg::GAP_MIN_RST), 600);
        send_pulse(32'(ookpd_pkg::GAP_MAX_RST), 600);
        send_pulse(32'(ookpd_pkg::SYNC_MIN_RST), 600);
        send_edge(1'b1, '1);
        send_edge(1'b0, '0);
        wait_idle();
    endtask

    task automatic test_frame_rules();
        ookpd_pkg::cfg_t c;
        c            = default_cfg();
        c.frame_bits = 7'd3;
        write_config(c);
        send_pulse(pick_sync(), pick_len());
        send_pulse(32'(ookpd_pkg::GAP_ONE_RST), 600);
        send_pulse(32'(ookpd_pkg::GAP_ONE_RST) + 1, 600);
        send_pulse(32'(ookpd_pkg::GAP_MIN_RST) + 1, 600);
        send_pulse(32'(ookpd_pkg::SYNC_MIN_RST), 600);
        wait_idle();
        // sync threshold inside the bit window, empty frame length
        c.sync_min   = ookpd_pkg::GAP_MIN_RST + 16'd500;
        c.frame_bits = '0;
        write_config(c);
        send_pulse(32'(ookpd_pkg::SYNC_MIN_RST) + 500, 600);
        send_pulse(32'(ookpd_pkg::GAP_MIN_RST) + 1000, 600);
        send_pulse(32'(ookpd_pkg::SYNC_MIN_RST) + 500, 600);
        wait_idle();
    endtask

    task automatic test_long_frames();
        ookpd_pkg::cfg_t c;
        c            = default_cfg();
        c.frame_bits = 7'(ookpd_pkg::CODE_WIDTH + 6);
        write_config(c);
        send_frame(ookpd_pkg::CODE_WIDTH + 6);
        send_pulse(pick_sync(), pick_len());
        wait_idle();
        // bit counter wraps back onto a short frame length
        c.frame_bits = 7'd2;
        write_config(c);
        send_frame(2 ** ookpd_pkg::COUNT_WIDTH + 2);
        send_pulse(pick_sync(), pick_len());
        wait_idle();
    endtask

    task automatic test_backpressure();
        write_config(rand_cfg());
        rx_hold_req = 400;
        run_frames(60, 90);
    endtask

    task automatic test_random_settings();
        write_config(default_cfg());
        run_frames(30, 85);
        idle_en = 1'b0;
        write_config(rand_cfg());
        run_frames(50, 85);
        idle_en = 1'b1;
        repeat (3) begin
            write_config(rand_cfg());
            run_frames(25, 80);
        end
        write_config(make_cfg('0, '1, '0, 16'h8000, '1, '1, 7'(ookpd_pkg::CODE_WIDTH)));
        run_frames(40, 85);
        write_config(make_cfg('1, '1, '1, '1, '1, '1, '1));
        run_frames(16, 50);
        write_config(make_cfg('0, '0, '0, '0, '0, '0, '0));
        run_frames(16, 50);
    endtask

    initial begin
        thresholds = default_cfg();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        test_window_edges();
        test_frame_rules();
        test_long_frames();
        test_backpressure();
        test_random_settings();
        $display("covered %0d edges under %0d threshold settings, incl. wrap and hold-off",
                 edges_sent, settings_used);
        $display("%0d results checked, %0d frames decoded, %0d mismatches",
                 results_seen, frames_seen, err_cnt);
        if (err_cnt == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
